// ----- rtl/txc_pkg.sv -----
// shared constants, types and codes for the text console writer
`default_nettype none
package txc_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int CW = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int AW = $clog2(CELLS);

  // fixed field widths
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int PW     = (AW > POS_W) ? AW : POS_W;
  // wide enough for line * COLUMNS + column at any port value
  localparam int MW     = 14;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, BLANK_CHAR};

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [ATTR_W-1:0] attr;
    logic              bad;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/txc_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/txc_ctrl.sv -----
// command sequencer: cursor, scroll copy, fill sweeps and cell access
`default_nettype none
module txc_ctrl import txc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              text_attr_we,
  input  wire logic [ATTR_W-1:0] text_attr_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [6:0]        column,
  input  wire logic [4:0]        line,
  input  wire logic [ATTR_W-1:0] new_attr,
  input  wire logic              out_free,
  output logic                   res_push,
  output result_t                res,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [CELL_W-1:0]      ram_wdata,
  output logic [AW-1:0]          ram_raddr,
  input  wire logic [CELL_W-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SCROLL,
    S_SCROLL_LAST,
    S_FILL,
    S_RESULT
  } state_t;

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

  state_t            state;
  logic [ATTR_W-1:0] text_attr;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [AW-1:0]     row_base;
  mode_t             cmd_mode;
  logic [CHAR_W-1:0] cmd_char;
  logic [ATTR_W-1:0] cmd_attr;
  logic              cmd_bad;
  logic [AW-1:0]     cell_addr;
  logic [ATTR_W-1:0] res_attr;
  logic [AW-1:0]     fill_addr;
  logic [CELL_W-1:0] fill_data;
  logic              fill_report;
  logic [AW-1:0]     sc_rd;
  logic [AW-1:0]     sc_wr;
  logic              sc_wr_valid;

  logic [MW-1:0]     prod;
  logic              in_bad;
  logic [CW-1:0]     bs_col;
  logic [RW-1:0]     bs_row;
  logic [AW-1:0]     bs_base;
  logic [AW-1:0]     cur_addr;
  logic [PW-1:0]     pos_wide;
  logic              is_special;

  assign in_ready = (state == S_IDLE);
  assign prod     = MW'(line) * MW'(COLUMNS) + MW'(column);
  assign in_bad   = ({1'b0, column} >= 8'(COLUMNS)) || ({1'b0, line} >= 6'(ROWS));
  assign cur_addr = row_base + AW'(col);
  assign pos_wide = PW'(row_base) + PW'(col);
  assign is_special = (cmd_char == CH_NEWLINE) || (cmd_char == CH_RETURN) ||
                      (cmd_char == CH_BACKSPACE);

  // backspace target, stepping across a line start
  always_comb begin
    bs_col  = col;
    bs_row  = row;
    bs_base = row_base;
    if (col != '0) begin
      bs_col = col - 1'b1;
    end else if (row != '0) begin
      bs_col  = COL_LAST;
      bs_row  = row - 1'b1;
      bs_base = row_base - COL_STEP;
    end
  end

  assign res_push  = (state == S_RESULT) && out_free;
  assign res.pos   = pos_wide[POS_W-1:0];
  assign res.attr  = res_attr;
  assign res.bad   = cmd_bad;
  assign ram_raddr = (state == S_SCROLL) ? sc_rd : cell_addr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_addr;
    ram_wdata = fill_data;
    unique case (state)
      S_DECODE: begin
        if (cmd_mode == MODE_PUT && cmd_char == CH_BACKSPACE) begin
          ram_we    = 1'b1;
          ram_waddr = bs_base + AW'(bs_col);
          ram_wdata = {text_attr, BLANK_CHAR};
        end else if (cmd_mode == MODE_PUT && !is_special) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = {text_attr, cmd_char};
        end
      end
      S_RD_WAIT: begin
        if (cmd_mode == MODE_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr;
          ram_wdata = {cmd_attr, ram_rdata[CHAR_W-1:0]};
        end
      end
      S_SCROLL, S_SCROLL_LAST: begin
        ram_we    = sc_wr_valid;
        ram_waddr = sc_wr;
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      text_attr   <= RESET_ATTR;
      col         <= '0;
      row         <= '0;
      row_base    <= '0;
      fill_addr   <= '0;
      fill_data   <= RESET_BLANK;
      fill_report <= 1'b0;
      sc_wr_valid <= 1'b0;
    end else begin
      if (text_attr_we) begin
        text_attr <= text_attr_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_mode  <= mode_t'(mode);
            cmd_char  <= char_code;
            cmd_attr  <= new_attr;
            cmd_bad   <= (mode_t'(mode) == MODE_READ || mode_t'(mode) == MODE_WRITE) &&
                         in_bad;
            cell_addr <= prod[AW-1:0];
            res_attr  <= '0;
            state     <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_RESULT;
          unique case (cmd_mode)
            MODE_PUT: begin
              if (cmd_char == CH_RETURN) begin
                col <= '0;
              end else if (cmd_char == CH_BACKSPACE) begin
                col      <= bs_col;
                row      <= bs_row;
                row_base <= bs_base;
              end else if (cmd_char == CH_NEWLINE || col == COL_LAST) begin
                // row advance, scrolling at the bottom
                col <= '0;
                if (row == ROW_LAST) begin
                  sc_rd       <= COL_STEP;
                  sc_wr_valid <= 1'b0;
                  state       <= S_SCROLL;
                end else begin
                  row      <= row + 1'b1;
                  row_base <= row_base + COL_STEP;
                end
              end else begin
                col <= col + 1'b1;
              end
            end
            MODE_CLEAR: begin
              col         <= '0;
              row         <= '0;
              row_base    <= '0;
              fill_addr   <= '0;
              fill_data   <= {text_attr, BLANK_CHAR};
              fill_report <= 1'b1;
              state       <= S_FILL;
            end
            MODE_READ, MODE_WRITE: begin
              if (!cmd_bad) begin
                state <= S_RD_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
        S_RD_WAIT: begin
          if (cmd_mode == MODE_READ) begin
            res_attr <= ram_rdata[CELL_W-1:CHAR_W];
          end
          state <= S_RESULT;
        end
        S_SCROLL: begin
          sc_wr_valid <= 1'b1;
          sc_wr       <= sc_rd - COL_STEP;
          sc_rd       <= sc_rd + 1'b1;
          if (sc_rd == CELL_LAST) begin
            state <= S_SCROLL_LAST;
          end
        end
        S_SCROLL_LAST: begin
          sc_wr_valid <= 1'b0;
          fill_addr   <= AW'(CELLS - COLUMNS);
          fill_data   <= {text_attr, BLANK_CHAR};
          fill_report <= 1'b1;
          state       <= S_FILL;
        end
        S_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == CELL_LAST) begin
            state <= fill_report ? S_RESULT : S_IDLE;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/text_console_writer_core.sv -----
// top level of the text console writer: screen ram, sequencer, output register
//
// character-cell text console with a COLUMNS x ROWS screen of 16-bit cells
// (attribute in the high byte, character in the low byte) held in one
// single-port-write, registered-read ram, plus a cursor. each accepted word
// is one command (put character, clear, read attribute, write attribute)
// and yields exactly one result word with the linear cursor position. the
// block works on one word at a time: a put, return or newline without scroll
// goes through the decode state to the result state, which loads the output
// register once it is free; an attribute read or write at a good position
// also passes the read-wait state. a scroll copies every row below the top
// up one row through the ram, one cell per cycle, then blanks the bottom row;
// a clear sweeps every cell. after reset the ram is swept to blank cells
// with attribute 0x0F while in_ready stays low; text_attr writes are taken
// at any time. the ram's single write port paces these sweeps. a finished
// result sits in an output register, so the next word can be accepted while
// it waits.
`default_nettype none
module text_console_writer_core import txc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              text_attr_we,
  input  wire logic [ATTR_W-1:0] text_attr_wdata,
  // command channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [6:0]        column,
  input  wire logic [4:0]        line,
  input  wire logic [ATTR_W-1:0] new_attr,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       cursor_pos,
  output logic [ATTR_W-1:0]      cell_attr,
  output logic                   bad_position
);

  logic              out_free;
  logic              res_push;
  result_t           res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // output slot can take a new word when empty or draining this cycle
  assign out_free = !out_valid || out_ready;

  // screen store
  txc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  txc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .text_attr_we    (text_attr_we),
    .text_attr_wdata (text_attr_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .char_code       (char_code),
    .column          (column),
    .line            (line),
    .new_attr        (new_attr),
    .out_free        (out_free),
    .res_push        (res_push),
    .res             (res),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  // result register, holds its word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_push) begin
        out_valid    <= 1'b1;
        cursor_pos   <= res.pos;
        cell_attr    <= res.attr;
        bad_position <= res.bad;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/txc_checker.sv -----
// port-level checks for the text console writer, bound to the top level
`default_nettype none
module txc_checker import txc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [POS_W-1:0]  cursor_pos,
  input wire logic [ATTR_W-1:0] cell_attr,
  input wire logic              bad_position
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_pos) &&
    $stable(cell_attr) && $stable(bad_position))
    else $error("result word changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  // an ignored position reads no attribute
  a_bad_attr: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_position |-> cell_attr == '0)
    else $error("attribute reported for a bad position");

  // a result always names a cursor on the screen
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(cursor_pos) < CELLS)
    else $error("cursor position off screen");

endmodule

bind text_console_writer_core txc_checker u_txc_checker (.*);
`default_nettype wire
